/* rtl/joystick_axis_auto_zero_normalizer_unit_assert.svh */
// assertion macros for the joystick axis auto-zero normaliser
// expects clock aclk and active-low reset aresetn in the including module
`ifndef JOYSTICK_AXIS_AUTO_ZERO_NORMALIZER_UNIT_ASSERT_SVH
`define JOYSTICK_AXIS_AUTO_ZERO_NORMALIZER_UNIT_ASSERT_SVH

// same-cycle implication
`define JAAZN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JAAZN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/jaazn_pkg.sv */
// shared types and constants of the joystick axis auto-zero normaliser
// no dependencies
`default_nettype none

package jaazn_pkg;

    localparam int SAMPLE_BITS    = 12;
    localparam int FRAC_BITS      = 14;
    localparam int COUNT_BITS_DEF = 17;
    localparam int POS_W          = 16;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int RATE_W         = 10;
    localparam int STARTUP_W      = 16;
    localparam int PROD_W         = STARTUP_W + RATE_W;
    // quotient bits of the shared divider: covers 0..2^FRAC_BITS
    localparam int QUO_BITS       = FRAC_BITS + 1;
    localparam int THOUSAND       = 1000;
    localparam int JUMP_FACTOR    = 20;
    localparam int ONE_Q_INT      = 1 << FRAC_BITS;
    localparam int SAMPLE_MASK    = (1 << SAMPLE_BITS) - 1;

    localparam logic [SAMPLE_BITS-1:0] ZERO_RESET    = SAMPLE_BITS'(2048);
    localparam logic [SAMPLE_BITS-1:0] ENDPOINT_RESET = SAMPLE_BITS'(4095);
    localparam logic [STARTUP_W-1:0]   STARTUP_RESET = STARTUP_W'(500);
    localparam logic [RATE_W-1:0]      RATE_RESET    = RATE_W'(100);
    localparam logic signed [POS_W-1:0] START_POS_RESET = '0;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_INIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENDPOINT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_AVG   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STARTUP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_POS  = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_END,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_CAL,
        OP_NORM_SET,
        OP_DIV_NORM,
        OP_DIV_AVG,
        OP_COMMIT,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic cal_mode;
        logic steady;
        logic direct;
        logic end_reached;
        logic div_done;
    } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/jaazn_div.sv */
// serial restoring divider, one quotient bit per cycle
// depends on jaazn_pkg
`default_nettype none

module jaazn_div #(
    parameter int DIV_W = jaazn_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [DIV_W-1:0]              rem_init,
    input  wire logic [jaazn_pkg::QUO_BITS-1:0] low_bits,
    input  wire logic [DIV_W-1:0]              divisor,
    output logic                               done,
    output logic [jaazn_pkg::QUO_BITS-1:0]     quotient
);
    import jaazn_pkg::*;

    localparam int CNT_W = $clog2(QUO_BITS);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [QUO_BITS-1:0] low_reg, low_next;
    logic [QUO_BITS-1:0] quo_reg, quo_next;

    logic [DIV_W:0] rem_sh;
    logic [DIV_W:0] rem_sub;
    logic           ge;

    assign rem_sh  = {rem_reg, low_reg[QUO_BITS-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = rem_init;
            dvs_next  = divisor;
            low_next  = low_bits;
        end else if (busy_reg) begin
            rem_next = ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            low_next = {low_reg[QUO_BITS-2:0], 1'b0};
            quo_next = {quo_reg[QUO_BITS-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(QUO_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* rtl/jaazn_dp.sv */
// datapath: configuration registers, calibration state, normalisation and output register
// depends on jaazn_pkg and jaazn_div
`default_nettype none

module jaazn_dp #(
    parameter int COUNT_BITS = jaazn_pkg::COUNT_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [jaazn_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [jaazn_pkg::CFG_W-1:0]        cfg_wdata,
    input  wire logic [jaazn_pkg::SAMPLE_BITS-1:0]  sample,
    input  wire jaazn_pkg::dp_cmd_t                 cmd,
    output jaazn_pkg::dp_stat_t                     stat,
    output logic signed [jaazn_pkg::POS_W-1:0]      position,
    output logic                                    calibrating,
    output logic [jaazn_pkg::SAMPLE_BITS-1:0]       zero_point
);
    import jaazn_pkg::*;

    localparam int SUM_W = COUNT_BITS + SAMPLE_BITS;
    localparam int DIV_W = (COUNT_BITS > SAMPLE_BITS) ? COUNT_BITS : SAMPLE_BITS;
    localparam int CMP_W = (COUNT_BITS + 11 > PROD_W) ? COUNT_BITS + 11 : PROD_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // configuration
    logic [SAMPLE_BITS-1:0] endpoint_reg;
    logic                   zero_avg_reg;
    logic [STARTUP_W-1:0]   startup_reg;
    logic [RATE_W-1:0]      rate_reg;

    // calibration and position state
    logic                   warmup_reg;
    logic [SAMPLE_BITS-1:0] prev_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [SAMPLE_BITS-1:0] zero_reg;
    logic signed [POS_W-1:0] held_reg;

    // per-item working registers
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic                   neg_reg;
    logic                   avg_mode_reg;
    logic signed [POS_W-1:0] pos_out_reg;
    logic                   cal_out_reg;
    logic [SAMPLE_BITS-1:0] zero_out_reg;

    logic [SAMPLE_BITS-1:0]   diff;
    logic [SAMPLE_BITS+4:0]   diff20;
    logic                     steady;
    logic                     neg;
    logic [SAMPLE_BITS-1:0]   anum;
    logic [SAMPLE_BITS-1:0]   den;
    logic                     direct;
    logic signed [POS_W-1:0]  direct_pos;
    logic [COUNT_BITS:0]      count_p1;
    logic [CMP_W-1:0]         lhs;
    logic                     end_reached;
    logic                     div_start;
    logic [DIV_W-1:0]         div_rem_init;
    logic [QUO_BITS-1:0]      div_low;
    logic [DIV_W-1:0]         div_divisor;
    logic                     div_done;
    logic [QUO_BITS-1:0]      div_quo;
    logic signed [POS_W-1:0]  quo_pos;
    logic                     cal_mode;

    localparam logic signed [POS_W-1:0] ONE_Q = POS_W'(ONE_Q_INT);

    assign cal_mode = warmup_reg & zero_avg_reg;

    // jump test
    assign diff   = (sample_reg > prev_reg) ? sample_reg - prev_reg : prev_reg - sample_reg;
    assign diff20 = (SAMPLE_BITS+5)'(diff) * (SAMPLE_BITS+5)'(JUMP_FACTOR);
    assign steady = diff20 <= (SAMPLE_BITS+5)'(SAMPLE_MASK);

    // normalisation operands
    assign neg    = sample_reg < zero_reg;
    assign anum   = neg ? zero_reg - sample_reg : sample_reg - zero_reg;
    assign den    = (endpoint_reg >= zero_reg) ? endpoint_reg - zero_reg
                                               : zero_reg - endpoint_reg;
    assign direct = (den == '0) || (anum > den);
    assign direct_pos = (anum == '0) ? '0 : (neg ? -ONE_Q : ONE_Q);

    // end of startup period
    assign count_p1    = {1'b0, count_reg} + (COUNT_BITS+1)'(1);
    assign lhs         = CMP_W'(count_p1) * CMP_W'(THOUSAND);
    assign end_reached = (lhs > CMP_W'(prod_reg)) || (count_reg == COUNT_MAX);

    assign div_start = (cmd.op == OP_DIV_NORM) || (cmd.op == OP_DIV_AVG);

    always_comb begin
        if (cmd.op == OP_DIV_AVG) begin
            div_rem_init = DIV_W'(sum_reg >> QUO_BITS);
            div_low      = sum_reg[QUO_BITS-1:0];
            div_divisor  = DIV_W'(count_reg);
        end else begin
            // dividend is anum shifted up by the fraction bits
            div_rem_init = DIV_W'(anum >> 1);
            div_low      = {anum[0], {FRAC_BITS{1'b0}}};
            div_divisor  = DIV_W'(den);
        end
    end

    jaazn_div #(
        .DIV_W(DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .rem_init (div_rem_init),
        .low_bits (div_low),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign quo_pos = POS_W'(div_quo);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            endpoint_reg   <= ENDPOINT_RESET;
            zero_avg_reg   <= 1'b0;
            startup_reg    <= STARTUP_RESET;
            rate_reg       <= RATE_RESET;
            warmup_reg     <= 1'b1;
            prev_reg       <= '0;
            sum_reg        <= '0;
            count_reg      <= '0;
            zero_reg       <= ZERO_RESET;
            held_reg       <= START_POS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ZERO_INIT: zero_reg      <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_ENDPOINT:  endpoint_reg  <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_ZERO_AVG:  zero_avg_reg  <= cfg_wdata[0];
                REG_STARTUP:   startup_reg   <= cfg_wdata[STARTUP_W-1:0];
                REG_TICK_RATE: rate_reg      <= cfg_wdata[RATE_W-1:0];
                REG_START_POS: held_reg      <= signed'(cfg_wdata[POS_W-1:0]);
                default: ;
            endcase
        end else begin
            case (cmd.op)
                OP_CAL: begin
                    prev_reg <= sample_reg;
                    if (steady) begin
                        sum_reg <= sum_reg + SUM_W'(sample_reg);
                        if (count_reg != COUNT_MAX) begin
                            count_reg <= count_reg + COUNT_BITS'(1);
                        end
                    end
                end
                OP_NORM_SET: held_reg <= direct_pos;
                OP_COMMIT: begin
                    if (avg_mode_reg) begin
                        zero_reg   <= div_quo[SAMPLE_BITS-1:0];
                        warmup_reg <= 1'b0;
                    end else begin
                        held_reg <= neg_reg ? -quo_pos : quo_pos;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) begin
            sample_reg <= sample;
        end
        if (cmd.op == OP_CAL) begin
            prod_reg <= PROD_W'(startup_reg) * PROD_W'(rate_reg);
        end
        if (div_start) begin
            neg_reg      <= neg;
            avg_mode_reg <= (cmd.op == OP_DIV_AVG);
        end
        if (cmd.op == OP_OUT) begin
            pos_out_reg  <= held_reg;
            cal_out_reg  <= cal_mode;
            zero_out_reg <= zero_reg;
        end
    end

    assign stat.cal_mode    = cal_mode;
    assign stat.steady      = steady;
    assign stat.direct      = direct;
    assign stat.end_reached = end_reached;
    assign stat.div_done    = div_done;

    assign position    = pos_out_reg;
    assign calibrating = cal_out_reg;
    assign zero_point  = zero_out_reg;

endmodule

`default_nettype wire

/* rtl/jaazn_ctrl.sv */
// controller state machine: sequences one sample through the datapath
// depends on jaazn_pkg and the assertion macro header
`default_nettype none
`include "joystick_axis_auto_zero_normalizer_unit_assert.svh"

module jaazn_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    input  wire jaazn_pkg::dp_stat_t stat,
    output jaazn_pkg::dp_cmd_t       cmd
);
    import jaazn_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_CHECK;
            ST_CHECK: begin
                if (stat.cal_mode) begin
                    state_next = stat.steady ? ST_END : ST_OUT;
                end else begin
                    state_next = stat.direct ? ST_OUT : ST_DIV;
                end
            end
            ST_END:   state_next = stat.end_reached ? ST_DIV : ST_OUT;
            ST_DIV:   if (stat.div_done) state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.op   = OP_NONE;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) cmd.op = OP_LOAD;
            end
            ST_CHECK: begin
                if (stat.cal_mode) begin
                    cmd.op = OP_CAL;
                end else begin
                    cmd.op = stat.direct ? OP_NORM_SET : OP_DIV_NORM;
                end
            end
            ST_END:  if (stat.end_reached) cmd.op = OP_DIV_AVG;
            ST_DIV:  if (stat.div_done) cmd.op = OP_COMMIT;
            ST_OUT:  if (out_free) cmd.op = OP_OUT;
            default: cmd.op = OP_NONE;
        endcase
    end

    always_comb begin
        if (cmd.op == OP_OUT) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    `JAAZN_ASSERT_NEXT(a_accept_to_check, s_tvalid && s_tready, state_reg == ST_CHECK, "accepted sample not evaluated")
    `JAAZN_ASSERT_NEXT(a_out_sets_valid, cmd.op == OP_OUT, m_tvalid_reg, "result load lost")
    `JAAZN_ASSERT_NEXT(a_div_waits, state_reg == ST_DIV && !stat.div_done, state_reg == ST_DIV, "left divide early")

endmodule

`default_nettype wire

/* rtl/joystick_axis_auto_zero_normalizer_unit.sv */
// top level of the joystick axis auto-zero normaliser
// depends on jaazn_pkg, jaazn_ctrl, jaazn_dp (and jaazn_div below it)
//
//  channel   direction  payload
//  s_*       in         tdata[11:0] sample
//  m_*       out        tdata[15:0] position, tdata[27:16] zero_point, tuser calibrating
//  cfg_*     in         register index and write data, no read-back
//
// a position that needs no division, or a jump that is only stored, skips the divider; a steady
// calibration tick also checks the end of the startup period; a position quotient and the
// average that closes calibration go through the 15-step serial divider and wait for its done flag
// the next sample is taken while the previous result waits in the output register
// a stalled result holds the block in its output state until m_tready
// reset (aresetn low, synchronous) restarts calibration and loads the register defaults

`default_nettype none

module joystick_axis_auto_zero_normalizer_unit #(
    parameter int COUNT_BITS = jaazn_pkg::COUNT_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [15:0]                     s_tdata,   // [11:0] sample
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [31:0]                          m_tdata,   // [15:0] position, [27:16] zero_point
    output logic                                 m_tuser,   // [0] calibrating
    input  wire logic                            cfg_we,
    input  wire logic [jaazn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [jaazn_pkg::CFG_W-1:0]     cfg_wdata
);
    import jaazn_pkg::*;

    dp_cmd_t                 cmd;
    dp_stat_t                stat;
    logic signed [POS_W-1:0] position;
    logic                    calibrating;
    logic [SAMPLE_BITS-1:0]  zero_point;

    jaazn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    jaazn_dp #(
        .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .sample      (s_tdata[SAMPLE_BITS-1:0]),
        .cmd         (cmd),
        .stat        (stat),
        .position    (position),
        .calibrating (calibrating),
        .zero_point  (zero_point)
    );

    assign m_tdata = {4'b0000, zero_point, position};
    assign m_tuser = calibrating;

endmodule

`default_nettype wire
